// File: hdl/fpsa_pkg.sv
// Package for the free page stack allocator: operation and status codes,
// common widths and the walk state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fpsa_pkg;

  // Fixed payload widths
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // Operation codes carried by a request
  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_REQUEST = 2'd1,
    OP_FREE    = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NULL  = 2'd3
  } status_e;

  // Region walk state: next page address and bytes still to cover
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] rem;
  } walk_t;

endpackage

`default_nettype wire

// File: hdl/fpsa_if.sv
// Valid/ready channel interfaces for the allocator: the request channel and
// the result channel. Depends on fpsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface fpsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [fpsa_pkg::OP_W-1:0]   operation;
  logic [fpsa_pkg::ADDR_W-1:0] region_base;
  logic [fpsa_pkg::ADDR_W-1:0] region_length;
  logic                        region_usable;
  logic [fpsa_pkg::ADDR_W-1:0] page_address;

  modport source (
    output valid, operation, region_base, region_length, region_usable, page_address,
    input  ready
  );
  modport sink (
    input  valid, operation, region_base, region_length, region_usable, page_address,
    output ready
  );
endinterface

interface fpsa_res_if #(
  parameter int unsigned CNT_W = 13
);
  logic                          valid;
  logic                          ready;
  logic [fpsa_pkg::ADDR_W-1:0]   granted_address;
  logic [fpsa_pkg::STATUS_W-1:0] status;
  logic [CNT_W-1:0]              free_count;

  modport source (
    output valid, granted_address, status, free_count,
    input  ready
  );
  modport sink (
    input  valid, granted_address, status, free_count,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/fpsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fpsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/fpsa_step.sv
// Walk step unit: advances the page address by one page and takes a
// page off the remaining length, saturating at zero. Depends on fpsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpsa_step #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  fpsa_pkg::walk_t cur_i,
  output fpsa_pkg::walk_t nxt_o
);

  localparam int unsigned AW = fpsa_pkg::ADDR_W;

  logic [AW:0] diff;

  // One subtract with borrow out; a borrow means the last page is partial
  assign diff = {1'b0, cur_i.rem} - (AW + 1)'(PAGE_BYTES);

  assign nxt_o.addr = cur_i.addr + AW'(PAGE_BYTES);
  assign nxt_o.rem  = diff[AW] ? '0 : diff[AW-1:0];

endmodule

`default_nettype wire

// File: hdl/free_page_stack_allocator_unit.sv
// Free page stack allocator: LIFO of free page addresses in one RAM.
// Free, failed request and no-op add give a result in the cycle after the
// request; a good request reads the RAM in S_READ first; add-region pushes
// its pages in S_WALK, paced by the walk step unit and the RAM write port.
// Throughput: one request at a time; next request taken once the result goes.
// Reset clears stack pointer and capacity; RAM contents are left undefined.
`timescale 1ns / 1ps
`default_nettype none

module free_page_stack_allocator_unit #(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned PAGE_BYTES  = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  fpsa_req_if.sink      req_i,
  fpsa_res_if.source    res_o
);

  localparam int unsigned AW    = fpsa_pkg::ADDR_W;
  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    top_q, top_d;
  logic [CNT_W-1:0]    cap_q, cap_d;
  logic [CNT_W-1:0]    top_dec, top_inc;
  fpsa_pkg::walk_t     walk_q, walk_d, walk_nxt;
  fpsa_pkg::status_e   status_q, status_d;
  logic [AW-1:0]       gnt_q, gnt_d;

  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  logic [AW-1:0]       ram_wdata, ram_rdata;
  logic                req_fire;

  assign top_dec  = top_q - CNT_W'(1);
  assign top_inc  = top_q + CNT_W'(1);
  assign req_fire = req_i.valid && req_i.ready;

  // Page store
  fpsa_ram #(
    .WIDTH (AW),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (top_dec[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Walk step unit
  fpsa_step #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_step (
    .cur_i (walk_q),
    .nxt_o (walk_nxt)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    cap_d     = cap_q;
    walk_d    = walk_q;
    status_d  = status_q;
    gnt_d     = gnt_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = top_q[IDX_W-1:0];
    ram_wdata = walk_q.addr;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          gnt_d    = '0;
          status_d = fpsa_pkg::ST_OK;
          state_d  = S_RESP;
          unique case (fpsa_pkg::op_e'(req_i.operation))
            fpsa_pkg::OP_ADD: begin
              if (req_i.region_usable && (req_i.region_length != '0)) begin
                walk_d.addr = req_i.region_base;
                walk_d.rem  = req_i.region_length;
                state_d     = S_WALK;
              end
            end
            fpsa_pkg::OP_REQUEST: begin
              if (top_q == '0) begin
                status_d = fpsa_pkg::ST_EMPTY;
              end else begin
                top_d   = top_dec;
                ram_re  = 1'b1;
                state_d = S_READ;
              end
            end
            fpsa_pkg::OP_FREE: begin
              if (req_i.page_address == '0) begin
                status_d = fpsa_pkg::ST_NULL;
              end else if (top_q >= cap_q) begin
                // capacity never exceeds the store depth
                status_d = fpsa_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = req_i.page_address;
                top_d     = top_inc;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (walk_q.rem == '0) begin
          state_d = S_RESP;
        end else if (top_q == CNT_W'(STORE_DEPTH)) begin
          // store full: remaining pages dropped
          status_d = fpsa_pkg::ST_FULL;
          state_d  = S_RESP;
        end else begin
          ram_we = 1'b1;
          top_d  = top_inc;
          if (cap_q != CNT_W'(STORE_DEPTH)) begin
            cap_d = cap_q + CNT_W'(1);
          end
          walk_d = walk_nxt;
        end
      end

      S_READ: begin
        gnt_d   = ram_rdata;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (res_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      cap_q   <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cap_q   <= cap_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    walk_q   <= walk_d;
    status_q <= status_d;
    gnt_q    <= gnt_d;
  end

  // Channel outputs
  assign req_i.ready           = (state_q == S_IDLE);
  assign res_o.valid           = (state_q == S_RESP);
  assign res_o.granted_address = gnt_q;
  assign res_o.status          = status_q;
  assign res_o.free_count      = top_q;

`ifndef SYNTH
  a_top_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= cap_q)
    else $error("stack pointer above capacity");

  a_cap_within_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q <= CNT_W'(STORE_DEPTH))
    else $error("capacity above store depth");

  a_read_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_RESP && $stable(top_q))
    else $error("read did not complete into a result");

  a_walk_pushes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK && $past(state_q) == S_WALK |-> top_q == $past(top_q) + CNT_W'(1))
    else $error("walk step did not push exactly one page");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for free_page_stack_allocator_unit: drives add, request
// and free operations with random gaps and back-pressure, and checks every
// result. Depends on fpsa_pkg, fpsa_if and the allocator RTL.

module tb;
  import fpsa_pkg::*;

  localparam int unsigned STACK_DEPTH = 4096;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned COUNT_W     = 13;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PHASE_ITEMS = 510;
  // operation code with no meaning: the block must answer OK and do nothing
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0]   granted;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } page_grant_t;

  // Shadow of the page stack plus the queue of grants still to arrive
  class page_stack_scoreboard;
    logic [ADDR_W-1:0] page_mem [STACK_DEPTH];
    int unsigned       held;
    int unsigned       capacity;
    page_grant_t       grant_q[$];
    int unsigned       errors;

    function new();
      held     = 0;
      capacity = 0;
      errors   = 0;
    endfunction

    // Apply one accepted request to the shadow stack and queue its grant
    function void note_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] base,
                               logic [ADDR_W-1:0] len, logic usable,
                               logic [ADDR_W-1:0] addr);
      page_grant_t       want;
      logic [ADDR_W-1:0] pages;
      logic [ADDR_W-1:0] room;
      logic [ADDR_W-1:0] take;
      logic [ADDR_W-1:0] walk;
      want.granted = '0;
      want.status  = ST_OK;
      case (op)
        OP_ADD: begin
          if (usable) begin
            pages = len / PAGE_BYTES;
            if (len % PAGE_BYTES != 0) pages++;
            room = STACK_DEPTH - held;
            take = (pages < room) ? pages : room;
            walk = base;
            for (longint unsigned k = 0; k < take; k++) begin
              page_mem[held] = walk;
              held++;
              walk += PAGE_BYTES;
            end
            capacity += 32'(take);
            if (capacity > STACK_DEPTH) capacity = STACK_DEPTH;
            if (pages > take) want.status = ST_FULL;
          end
        end
        OP_REQUEST: begin
          if (held == 0) begin
            want.status = ST_EMPTY;
          end else begin
            held--;
            want.granted = page_mem[held];
          end
        end
        OP_FREE: begin
          if (addr == '0) begin
            want.status = ST_NULL;
          end else if (held >= capacity || held >= STACK_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            page_mem[held] = addr;
            held++;
          end
        end
        default: ;
      endcase
      want.count = COUNT_W'(held);
      grant_q.push_back(want);
    endfunction

    function void report(string what, page_grant_t want, page_grant_t got);
      errors++;
      if (errors <= REPORT_MAX)
        $display("mismatch (%s): want addr %h st %0d cnt %0d, got addr %h st %0d cnt %0d",
                 what, want.granted, want.status, want.count,
                 got.granted, got.status, got.count);
    endfunction

    // Compare one accepted grant with the oldest one outstanding
    function void check_result(page_grant_t got);
      page_grant_t want;
      if (grant_q.size() == 0) begin
        want = '{default: '0};
        report("no request outstanding", want, got);
        return;
      end
      want = grant_q.pop_front();
      if (got.granted !== want.granted) report("granted address", want, got);
      else if (got.status !== want.status) report("status", want, got);
      else if (got.count !== want.count) report("free count", want, got);
    endfunction

    function int unsigned pending();
      return grant_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned sent_count;
  int unsigned quiet_cycles;
  logic        hold_res;

  page_stack_scoreboard sb;

  fpsa_req_if                       req_if ();
  fpsa_res_if #(.CNT_W(COUNT_W))    res_if ();

  free_page_stack_allocator_unit #(
    .STORE_DEPTH (STACK_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Result side back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= !hold_res && ($urandom_range(99) >= recv_idle_pct);
  end

  // Note accepted requests, check accepted grants
  always @(posedge clk_i) begin : monitor
    page_grant_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.granted = res_if.granted_address;
        got.status  = res_if.status;
        got.count   = res_if.free_count;
        sb.check_result(got);
      end
      if (req_if.valid && req_if.ready)
        sb.note_request(req_if.operation, req_if.region_base, req_if.region_length,
                        req_if.region_usable, req_if.page_address);
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one request and wait until it is taken; valid stays high afterwards
  task automatic issue(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] base,
                       input logic [ADDR_W-1:0] len, input logic usable,
                       input logic [ADDR_W-1:0] addr);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.region_base   <= base;
    req_if.region_length <= len;
    req_if.region_usable <= usable;
    req_if.page_address  <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent_count++;
  endtask

  // Stop offering and wait for every outstanding grant
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // One random request with random payload in the fields it does not use
  task automatic random_op(input int unsigned req_pct);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] addr;
    logic              usable;
    int unsigned       pick;
    base   = {$urandom, $urandom};
    len    = {$urandom, $urandom};
    addr   = {$urandom, $urandom};
    usable = 1'($urandom_range(1));
    pick   = $urandom_range(99);
    if (pick < 5) begin
      issue(OP_ADD, base, len, 1'b0, addr);
    end else if (pick < 9) begin
      issue(OP_FREE, base, len, usable, '0);
    end else if (pick < 11) begin
      issue(OP_NONE, base, len, usable, addr);
    end else if (pick < 11 + (89 * req_pct) / 100) begin
      issue(OP_REQUEST, base, len, usable, addr);
    end else begin
      if (addr == '0) addr = 64'h1000;
      issue(OP_FREE, base, len, usable, addr);
    end
  endtask

  // A small usable region: up to eight pages, base aligned or not
  task automatic small_region();
    logic [ADDR_W-1:0] base;
    base = {$urandom, $urandom};
    if ($urandom_range(1)) base[11:0] = '0;
    issue(OP_ADD, base, ADDR_W'($urandom_range(0, 8 * PAGE_BYTES)), 1'b1,
          {$urandom, $urandom});
  endtask

  // Random part: boot, churn and drain sequences
  task automatic random_phase(input int unsigned items);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n;
    stop_at = sent_count + items;
    while (sent_count < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        small_region();
      end else if (kind < 85) begin
        n = $urandom_range(10, 40);
        repeat (n) random_op(50);
      end else begin
        n = (sb.held < 100) ? sb.held + $urandom_range(1, 3) : 60;
        repeat (n) random_op(90);
      end
    end
  endtask

  // Edge cases of each operation, starting from an empty stack
  task automatic directed_ops();
    issue(OP_REQUEST, '0, '0, 1'b0, '0);                        // empty stack
    issue(OP_FREE, '0, '0, 1'b0, 64'h1000);                     // no capacity yet
    issue(OP_FREE, '0, '0, 1'b0, '0);                           // null address
    issue(OP_NONE, '0, '0, 1'b0, '0);
    issue(OP_ADD, 64'h4000_0000, 64'h8000, 1'b0, '0);           // not usable
    issue(OP_ADD, 64'h4000_0000, '0, 1'b1, '0);                 // zero length
    issue(OP_ADD, 64'h1000, 64'h1, 1'b1, '0);                   // part page
    issue(OP_ADD, 64'hFFFF_FFFF_FFFF_F000, 64'h3000, 1'b1, '0); // wraps to zero
    issue(OP_ADD, 64'h12345, 64'h2000, 1'b1, '0);               // exact pages
    issue(OP_FREE, '0, '0, 1'b0, 64'hDEAD_BEEF_0000_1000);      // at capacity
    issue(OP_REQUEST, '0, '0, 1'b0, '0);
    issue(OP_FREE, '0, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(OP_REQUEST, '0, '0, 1'b0, '0);
    issue(OP_FREE, '0, '0, 1'b0, 64'h8000_0000_0000_0000);
    issue(OP_FREE, '0, '0, 1'b0, 64'h1);
    repeat (8) issue(OP_REQUEST, '0, '0, 1'b0, '0);             // drain past empty
  endtask

  // Fill the whole stack, then poke at the full store
  task automatic fill_ops();
    issue(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '0);
    issue(OP_FREE, '0, '0, 1'b0, 64'h2000);
    issue(OP_ADD, {$urandom, $urandom}, {1'b1, 31'($urandom), $urandom}, 1'b1, '0);
    repeat (30) random_op(50);
    small_region();
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.operation     = OP_ADD;
    req_if.region_base   = '0;
    req_if.region_length = '0;
    req_if.region_usable = 1'b0;
    req_if.page_address  = '0;
    res_if.ready         = 1'b0;
    hold_res             = 1'b0;
    quiet_cycles         = 0;
    sent_count           = 0;
    send_idle_pct        = 21;
    recv_idle_pct        = 58;
    sb = new();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender idles now and then, receiver often
    directed_ops();
    wait_drained();
    fork
      begin
        hold_res <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_res <= 1'b0;
      end
    join_none
    random_phase(PHASE_ITEMS - 30);
    wait_drained();

    // Phase two: roles swapped
    send_idle_pct = 58;
    recv_idle_pct = 21;
    random_phase(PHASE_ITEMS);
    wait_drained();

    // Phase three: full rate both sides, ending with a fill of the whole stack
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_ITEMS - 40);
    fill_ops();

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: free_page_stack_allocator_unit.f
hdl/fpsa_pkg.sv
hdl/fpsa_if.sv
hdl/fpsa_ram.sv
hdl/fpsa_step.sv
hdl/free_page_stack_allocator_unit.sv
tb/sv/tb.sv
